@@ hdl/bpcrc_pkg.sv @@
package bpcrc_pkg;

  localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
  localparam logic [7:0]  PAD_BYTE         = 8'hFF;
  localparam logic [15:0] BLOCK_SIZE_RESET = 16'd4096;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } req_item_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic [31:0] padded_length;
  } res_item_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic take_pad;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pad_needed;
  } dp_status_t;

  // reflected CRC-32, one byte, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/block_padded_crc32.sv @@
// Block-padded CRC-32: takes an image one item a cycle (a byte when byte_valid
// is set) and keeps a reflected CRC-32 (poly 0xEDB88320, init all ones, no final
// inversion) with the length. An item marked last, with or without a byte, closes
// the image: the rest of the current erase block is fed as 0xFF bytes, one per
// cycle, then crc_value and the block-rounded padded_length are loaded into the
// result register and the image state clears. Ordinary items never stall; after
// a last item req_stall stays high while the pad bytes (up to block_size - 1) are fed
// and the result is loaded, longer if the previous result has not yet been taken.
// The pad bytes go one at a time through the single CRC byte unit. block_size (0 means
// 65536) is written on cfg_we and should only change while no image is in progress.
module block_padded_crc32 (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  bpcrc_pkg::req_item_t req,
  output logic                 res_valid,
  input  logic                 res_stall,
  output bpcrc_pkg::res_item_t res,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);
  import bpcrc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bpcrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bpcrc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .status   (status),
    .res      (res)
  );

endmodule

@@ hdl/bpcrc_ctrl.sv @@
module bpcrc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  bpcrc_pkg::req_item_t  req,
  output logic                  req_stall,
  output logic                  res_valid,
  input  logic                  res_stall,
  input  bpcrc_pkg::dp_status_t status,
  output bpcrc_pkg::dp_cmd_t    cmd
);
  import bpcrc_pkg::*;

  typedef enum logic {
    S_RUN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_stall = (state == S_FINISH);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    cmd.take_in  = (state == S_RUN) && req_valid && req.byte_valid;
    cmd.take_pad = (state == S_FINISH) && status.pad_needed;
    cmd.finish   = (state == S_FINISH) && !status.pad_needed && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (req_valid && req.last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (cmd.finish) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.last |=> req_stall)
    else $error("last item did not stop intake");
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> res_valid)
    else $error("result not presented after finish");
  a_pad_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take_pad && cmd.finish) && !(cmd.take_in && cmd.take_pad))
    else $error("conflicting datapath commands");
`endif

endmodule

@@ hdl/bpcrc_dp.sv @@
module bpcrc_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_data,
  input  bpcrc_pkg::req_item_t  req,
  input  bpcrc_pkg::dp_cmd_t    cmd,
  output bpcrc_pkg::dp_status_t status,
  output bpcrc_pkg::res_item_t  res
);
  import bpcrc_pkg::*;

  logic [15:0] block_size;
  logic [31:0] crc_reg;
  logic [15:0] block_offset;
  logic [31:0] length_count;

  logic [16:0] eff_size;
  logic [16:0] offset_inc;
  logic [7:0]  byte_in;
  logic        take;

  // zero means a 64 KiB block
  assign eff_size   = (block_size == 16'd0) ? 17'h1_0000 : {1'b0, block_size};
  assign offset_inc = {1'b0, block_offset} + 17'd1;
  assign byte_in    = cmd.take_pad ? PAD_BYTE : req.data_byte;
  assign take       = cmd.take_in || cmd.take_pad;

  // an offset at or past a lowered block size means no padding
  assign status.pad_needed = (block_offset != 16'd0) && ({1'b0, block_offset} < eff_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      block_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      crc_reg      <= CRC_INIT;
      block_offset <= 16'd0;
      length_count <= 32'd0;
    end else if (take) begin
      crc_reg      <= crc_byte(crc_reg, byte_in);
      length_count <= length_count + 32'd1;
      if (offset_inc >= eff_size) begin
        block_offset <= 16'd0;
      end else begin
        block_offset <= offset_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.crc_value     <= crc_reg;
      res.padded_length <= length_count;
    end
  end

`ifndef SYNTHESIS
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> crc_reg == CRC_INIT && block_offset == 16'd0 && length_count == 32'd0)
    else $error("image state not cleared after result");
  a_pad_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.take_pad |-> status.pad_needed)
    else $error("pad byte taken with block complete");
  a_finish_aligned: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !status.pad_needed)
    else $error("result taken before block boundary");
`endif

endmodule

@@ test/crc_checker.sv @@
`timescale 1ns / 1ps

module crc_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  bpcrc_pkg::req_item_t req,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  bpcrc_pkg::res_item_t res,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   sums_outstanding
);
  import bpcrc_pkg::*;

  res_item_t   sums_due[$];
  logic [31:0] crc_acc;
  logic [31:0] byte_total;
  logic [15:0] blk_pos;
  logic [15:0] blk_size;
  int          errors = 0;

  // one message bit per step, LSB first
  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // a size of zero stands for 64 KiB
  function automatic logic [16:0] erase_span();
    return (blk_size == 16'd0) ? 17'd65536 : {1'b0, blk_size};
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    logic [16:0] nxt;
    crc_acc    = crc32_shift_byte(crc_acc, b);
    byte_total = byte_total + 32'd1;
    nxt        = {1'b0, blk_pos} + 17'd1;
    blk_pos    = (nxt >= erase_span()) ? 16'd0 : nxt[15:0];
  endtask

  task automatic clear_image();
    crc_acc    = CRC_INIT;
    blk_pos    = 16'd0;
    byte_total = 32'd0;
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      blk_size = BLOCK_SIZE_RESET;
      clear_image();
      sums_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (sums_due.size() == 0) begin
          errors++;
          $error("unexpected result: crc_value %08h padded_length %08h",
                 res.crc_value, res.padded_length);
        end else begin
          want = sums_due.pop_front();
          if (res.crc_value !== want.crc_value) begin
            errors++;
            $error("crc_value: expected %08h, got %08h", want.crc_value, res.crc_value);
          end
          if (res.padded_length !== want.padded_length) begin
            errors++;
            $error("padded_length: expected %0d, got %0d",
                   want.padded_length, res.padded_length);
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (req.byte_valid) absorb_byte(req.data_byte);
        if (req.last) begin
          // fill to the next boundary only; an offset past a lowered size pads nothing
          while (blk_pos != 16'd0 && {1'b0, blk_pos} < erase_span()) absorb_byte(PAD_BYTE);
          sums_due.push_back('{crc_value: crc_acc, padded_length: byte_total});
          clear_image();
        end
      end
      if (cfg_we) blk_size = cfg_data;
    end
    fail_count       <= errors;
    sums_outstanding <= sums_due.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bpcrc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 8;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_item_t   req;
  logic        res_valid;
  logic        res_stall;
  res_item_t   res;
  logic        cfg_we;
  logic [15:0] cfg_data;
  int          fail_count;
  int          sums_outstanding;
  int          cycle_count = 0;
  bit          quiet       = 1'b0;
  bit          hold_off    = 1'b0;

  block_padded_crc32 dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  crc_checker chk (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .res              (res),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .sums_outstanding (sums_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** block_padded_crc32: FAILED **");
    $finish;
  end

  // result side: random hold-off per item, one long hold on request
  initial begin
    int gap;
    res_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (hold_off) begin
        hold_off = 1'b0;
        gap      = LONG_HOLD;
      end
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  task automatic send_item(input logic [7:0] d, input logic bv, input logic lst);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= '{data_byte: d, byte_valid: bv, last: lst};
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // stop offering, wait for every sum, then let a trailing item finish
  task automatic drain_and_settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sums_outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [15:0] bs);
    drain_and_settle();
    cfg_we   <= 1'b1;
    cfg_data <= bs;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one image of random length; close = 0 leaves it open across a size change
  task automatic random_image(input int span, inout int budget, input bit close);
    int len;
    int reps;
    bit end_on_byte;
    case ($urandom_range(0, 3))
      0: len = $urandom_range(0, 3);
      1: begin
        if (span <= 40) begin
          reps = (40 / span > 3) ? 3 : 40 / span;
          len  = span * $urandom_range(1, reps);
        end else begin
          len = $urandom_range(1, 40);
        end
      end
      2: len = $urandom_range(0, (2 * span < 40) ? 2 * span : 40);
      default: len = $urandom_range(1, 20);
    endcase
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, close && end_on_byte && (i == len - 1));
      budget--;
    end
    if (close && !end_on_byte) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      budget--;
    end
  endtask

  task automatic random_phase(input logic [15:0] bs, input int n_items, input bit calm);
    int span;
    int budget;
    write_block_size(bs);
    span   = (bs == 16'd0) ? 65536 : int'(bs);
    quiet  = calm;
    budget = n_items;
    while (budget > 0) random_image(span, budget, 1'b1);
    if ($urandom_range(0, 1) == 1) random_image(span, budget, 1'b0);
    quiet = 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset block size: empty image, then short images padded to 4 KiB
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);

    write_block_size(16'd1);
    send_item(8'h5A, 1'b1, 1'b1);

    // exact multiple of the block: no padding
    write_block_size(16'd4);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7E, 1'b1, 1'b0);
    send_item(8'hC3, 1'b1, 1'b1);

    // size lowered below the current offset, closed by an end-only item
    write_block_size(16'd8);
    for (int i = 0; i < 5; i++) send_item(pick_byte(), 1'b1, 1'b0);
    write_block_size(16'd4);
    send_item(8'h3C, 1'b0, 1'b1);

    // same, closed by a byte carrying last
    write_block_size(16'd8);
    for (int i = 0; i < 5; i++) send_item(pick_byte(), 1'b1, 1'b0);
    write_block_size(16'd4);
    send_item(8'hE7, 1'b1, 1'b1);

    random_phase(16'd1, 140, 1'b0);
    hold_off = 1'b1;
    random_phase(16'd2, 140, 1'b1);
    random_phase(16'd3, 140, 1'b0);
    random_phase(16'd7, 140, 1'b0);
    random_phase(16'd16, 140, 1'b1);
    random_phase(16'd64, 140, 1'b0);
    random_phase(16'd255, 130, 1'b0);
    random_phase(16'($urandom_range(1, 600)), 130, 1'b0);
    random_phase(16'($urandom_range(1, 40)), 130, 1'b0);

    // largest sizes, one short image each
    write_block_size(16'd0);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'hED, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    write_block_size(16'hFFFF);
    send_item(8'h81, 1'b1, 1'b1);

    drain_and_settle();
    if (fail_count == 0 && sums_outstanding == 0) begin
      $display("** block_padded_crc32: PASSED **");
    end else begin
      $display("** block_padded_crc32: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bpcrc_pkg.sv
hdl/bpcrc_ctrl.sv
hdl/bpcrc_dp.sv
hdl/block_padded_crc32.sv
test/crc_checker.sv
test/tb_top.sv
